// File: rtl/rv32i_pkg.sv
// Package for the RV32I instruction core: item types, opcodes and sequencer states.
// No dependencies.
package rv32i_pkg;
  localparam int MemWords = 16384;
  localparam int MemAw = $clog2(MemWords);

  localparam logic [1:0] REQ_MEM_WRITE = 2'd0;
  localparam logic [1:0] REQ_STEP      = 2'd1;
  localparam logic [1:0] REQ_REG_READ  = 2'd2;
  localparam logic [1:0] REQ_IGNORED   = 2'd3;

  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_FENCE  = 7'h0F;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FETCH, ST_DECODE, ST_EXEC, ST_MEM, ST_WB, ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [13:0] mem_index;
    logic [31:0] mem_data;
    logic [4:0]  reg_index;
  } req_t;

  typedef struct packed {
    logic        running;
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  dest_reg;
    logic [31:0] dest_value;
    logic [31:0] reg_value;
  } rsp_t;
endpackage

// File: rtl/rv32i_if.sv
// Valid/ready channel interfaces, each carrying one payload.
// Depends on rv32i_pkg for payload types.
interface rv32i_req_if import rv32i_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rv32i_rsp_if import rv32i_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/rv32i_alu.sv
// Shared arithmetic, compare and shift unit of the RV32I core.
// Depends on rv32i_pkg.
module rv32i_alu import rv32i_pkg::*; (
  input  logic [2:0]  fn3,
  input  logic        alt,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] y
);
  always_comb begin
    unique case (fn3)
      3'd0: y = alt ? a - b : a + b;
      3'd1: y = a << b[4:0];
      3'd2: y = {31'd0, $signed(a) < $signed(b)};
      3'd3: y = {31'd0, a < b};
      3'd4: y = a ^ b;
      3'd5: y = alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
      3'd6: y = a | b;
      default: y = a & b;
    endcase
  end
endmodule

// File: rtl/rv32i_instruction_core.sv
// Top level of the RV32I instruction core: sequencer, register file, PC and word memory.
// Depends on rv32i_pkg, the channel interfaces and rv32i_alu.
// A memory write, register read or ignored request goes through ST_WB and ST_DONE; a step
// goes through ST_FETCH, ST_DECODE, ST_EXEC, ST_MEM (loads, stores), ST_WB and ST_DONE, set
// by the single-port memory read for fetch and data and the one shared ALU used for the
// address, result and ordered branch compares; a request is accepted only from ST_IDLE.
module rv32i_instruction_core import rv32i_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_we,
  input logic [31:0] cfg_wdata,
  rv32i_req_if.sink   in_ch,
  rv32i_rsp_if.source out_ch
);
  state_t state_r, state_nxt;
  logic [31:0] mem [MemWords];
  logic [31:0] mrd_r;
  logic [31:0] rf_r [32];
  logic [31:0] pc_r, inst_r, a_r, b_r, addr_r, res_r, npc_r;
  req_t req_r;
  rsp_t rsp_r;
  logic running_r;
  logic wr_r;

  logic [MemAw-1:0] maddr;
  logic [31:0] mwdata;
  logic mwe;
  logic [2:0] alu_fn;
  logic alu_alt;
  logic [31:0] alu_a, alu_b, alu_y;

  wire [6:0] op = inst_r[6:0];
  wire [2:0] fn3 = inst_r[14:12];
  wire [4:0] rd = inst_r[11:7];
  wire [31:0] immi = {{20{inst_r[31]}}, inst_r[31:20]};
  wire [31:0] imms = {{20{inst_r[31]}}, inst_r[31:25], inst_r[11:7]};
  wire [31:0] immb = {{20{inst_r[31]}}, inst_r[7], inst_r[30:25], inst_r[11:8], 1'b0};
  wire [31:0] immj = {{12{inst_r[31]}}, inst_r[19:12], inst_r[20], inst_r[30:21], 1'b0};
  wire [31:0] immu = {inst_r[31:12], 12'd0};
  wire [4:0] sh = {addr_r[1:0], 3'd0};

  rv32i_alu u_alu (.fn3(alu_fn), .alt(alu_alt), .a(alu_a), .b(alu_b), .y(alu_y));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_ch.valid) begin
        state_nxt = (in_ch.data.req_type == REQ_STEP) ? ST_FETCH : ST_WB;
      end
      ST_FETCH:  state_nxt = ST_DECODE;
      ST_DECODE: state_nxt = ST_EXEC;
      ST_EXEC:   state_nxt = (op == OP_LOAD || op == OP_STORE) ? ST_MEM : ST_WB;
      ST_MEM:    state_nxt = ST_WB;
      ST_WB:     state_nxt = ST_DONE;
      ST_DONE:   if (out_ch.ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    alu_fn = 3'd0;
    alu_alt = 1'b0;
    alu_a = a_r;
    alu_b = b_r;
    unique case (op)
      OP_IMM: begin
        alu_fn = fn3; alu_b = immi; alu_alt = (fn3 == 3'd5) && inst_r[30];
      end
      OP_REG: begin
        alu_fn = fn3; alu_alt = inst_r[30];
      end
      OP_LOAD, OP_JALR: alu_b = immi;
      OP_STORE: alu_b = imms;
      OP_BRANCH: begin
        alu_fn = fn3[1] ? 3'd3 : 3'd2;
      end
      default: ;
    endcase
  end

  always_comb begin
    logic [31:0] m;
    m = '0;
    mwe = 1'b0;
    mwdata = mrd_r;
    maddr = pc_r[MemAw+1:2];
    if (state_r == ST_IDLE) begin
      maddr = in_ch.data.mem_index[MemAw-1:0];
      mwdata = in_ch.data.mem_data;
      mwe = in_ch.valid && (in_ch.data.req_type == REQ_MEM_WRITE);
    end else if (state_r == ST_EXEC) begin
      maddr = alu_y[MemAw+1:2];
    end else if (state_r == ST_MEM) begin
      maddr = addr_r[MemAw+1:2];
      if (op == OP_STORE) begin
        unique case (fn3)
          3'd0: m = 32'hFF << sh;
          3'd1: m = 32'hFFFF << sh;
          3'd2: m = 32'hFFFFFFFF;
          default: m = '0;
        endcase
        mwdata = (mrd_r & ~m) | ((b_r << sh) & m);
        mwe = (fn3 == 3'd0) || (fn3 == 3'd1) || (fn3 == 3'd2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mwe) mem[maddr] <= mwdata;
    mrd_r <= mem[maddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r <= '0;
      for (int i = 0; i < 32; i++) rf_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) pc_r <= cfg_wdata;
      if (state_r == ST_WB && req_r.req_type == REQ_STEP) begin
        pc_r <= npc_r;
        if (wr_r && rd != 5'd0) rf_r[rd] <= res_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [31:0] lw;
    logic take;
    lw = mrd_r >> sh;
    take = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        req_r <= in_ch.data;
      end
      ST_FETCH: ;
      ST_DECODE: begin
        inst_r <= mrd_r;
        a_r <= (mrd_r[19:15] == 5'd0) ? '0 : rf_r[mrd_r[19:15]];
        b_r <= (mrd_r[24:20] == 5'd0) ? '0 : rf_r[mrd_r[24:20]];
      end
      ST_EXEC: begin
        addr_r <= alu_y;
        running_r <= 1'b1;
        wr_r <= 1'b0;
        res_r <= alu_y;
        npc_r <= pc_r + 32'd4;
        unique case (op)
          OP_LUI: begin wr_r <= 1'b1; res_r <= immu; end
          OP_AUIPC: begin wr_r <= 1'b1; res_r <= pc_r + immu; end
          OP_JAL: begin wr_r <= 1'b1; res_r <= pc_r + 32'd4; npc_r <= pc_r + immj; end
          OP_JALR: begin
            wr_r <= 1'b1; res_r <= pc_r + 32'd4; npc_r <= alu_y & 32'hFFFFFFFE;
          end
          OP_BRANCH: begin
            unique case (fn3)
              3'd0: take = a_r == b_r;
              3'd1: take = a_r != b_r;
              3'd4, 3'd6: take = alu_y[0];
              3'd5, 3'd7: take = !alu_y[0];
              default: take = 1'b0;
            endcase
            if (take) npc_r <= pc_r + immb;
          end
          OP_IMM, OP_REG: wr_r <= 1'b1;
          OP_LOAD, OP_STORE, OP_FENCE: ;
          OP_SYSTEM: begin npc_r <= pc_r; running_r <= 1'b0; end
          default: npc_r <= pc_r;
        endcase
      end
      ST_MEM: begin
        if (op == OP_LOAD && req_r.req_type == REQ_STEP) begin
          wr_r <= 1'b1;
          unique case (fn3)
            3'd0: res_r <= {{24{lw[7]}}, lw[7:0]};
            3'd1: res_r <= {{16{lw[15] & ~(addr_r[1] & addr_r[0])}},
                            lw[15:8] & {8{~(addr_r[1] & addr_r[0])}}, lw[7:0]};
            3'd2: res_r <= mrd_r;
            3'd4: res_r <= {24'd0, lw[7:0]};
            3'd5: res_r <= {16'd0, lw[15:8] & {8{~(addr_r[1] & addr_r[0])}}, lw[7:0]};
            default: wr_r <= 1'b0;
          endcase
        end
      end
      ST_WB: ;
      ST_DONE: ;
      default: ;
    endcase
  end

  always_comb begin
    rsp_r = '0;
    rsp_r.running = 1'b1;
    rsp_r.next_pc = pc_r;
    if (req_r.req_type == REQ_STEP) begin
      rsp_r.running = running_r;
      if (wr_r && rd != 5'd0) begin
        rsp_r.reg_written = 1'b1;
        rsp_r.dest_reg = rd;
        rsp_r.dest_value = res_r;
      end
    end else if (req_r.req_type == REQ_REG_READ) begin
      rsp_r.reg_value = (req_r.reg_index == 5'd0) ? '0 : rf_r[req_r.reg_index];
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_ch.valid = (state_r == ST_DONE);
  assign out_ch.data = rsp_r;

  a_single_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("ready and valid together");
  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready) else $error("accepted twice");
  a_x0_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.reg_written |-> out_ch.data.dest_reg != 5'd0)
    else $error("write to x0 reported");
endmodule

// File: sim/testbench.sv
// Self-checking testbench for rv32i_instruction_core: directed table, then random programs.
// Depends on rv32i_pkg, the channel interfaces and the core RTL; it predicts every response.
module testbench import rv32i_pkg::*; ();
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  rv32i_req_if in_ch ();
  rv32i_rsp_if out_ch ();

  rv32i_instruction_core u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #5 clk = ~clk;

  localparam int WatchdogLimit = 20000;

  logic [31:0] core_regs [32];
  logic [31:0] core_mem [MemWords];
  bit          mem_valid [MemWords];
  logic [31:0] core_pc;
  rsp_t        expected_rsps [$];
  int          n_errors = 0;
  int          idle_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  typedef struct {
    req_t req;
    bit   has_exp;
    rsp_t exp;
  } vec_t;

  function automatic logic [31:0] shr_arith(logic [31:0] a, logic [4:0] sh);
    return $unsigned($signed(a) >>> sh);
  endfunction

  function automatic logic [31:0] alu_result(logic [2:0] fn3, logic [31:0] a, logic [31:0] b,
                                             bit alt);
    case (fn3)
      3'd0: alu_result = alt ? a - b : a + b;
      3'd1: alu_result = a << b[4:0];
      3'd2: alu_result = {31'd0, $signed(a) < $signed(b)};
      3'd3: alu_result = {31'd0, a < b};
      3'd4: alu_result = a ^ b;
      3'd5: alu_result = alt ? shr_arith(a, b[4:0]) : a >> b[4:0];
      3'd6: alu_result = a | b;
      default: alu_result = a & b;
    endcase
  endfunction

  function automatic logic [13:0] word_of(logic [31:0] addr);
    return addr[15:2];
  endfunction

  function automatic rsp_t core_predict(req_t r);
    rsp_t o;
    logic [31:0] inst, a, b, immi, imm, addr, res, npc, w, mask, lane;
    logic [6:0] op;
    logic [2:0] fn3;
    logic [4:0] d;
    bit wr, take;
    o = '0;
    o.running = 1'b1;
    if (r.req_type == REQ_MEM_WRITE) begin
      core_mem[r.mem_index] = r.mem_data;
      mem_valid[r.mem_index] = 1'b1;
    end else if (r.req_type == REQ_REG_READ) begin
      o.reg_value = core_regs[r.reg_index];
    end else if (r.req_type == REQ_STEP) begin
      inst = core_mem[word_of(core_pc)];
      op = inst[6:0];
      fn3 = inst[14:12];
      d = inst[11:7];
      a = core_regs[inst[19:15]];
      b = core_regs[inst[24:20]];
      immi = {{20{inst[31]}}, inst[31:20]};
      wr = 1'b0;
      res = '0;
      npc = core_pc + 32'd4;
      case (op)
        OP_LUI: begin
          wr = 1'b1;
          res = {inst[31:12], 12'd0};
        end
        OP_AUIPC: begin
          wr = 1'b1;
          res = core_pc + {inst[31:12], 12'd0};
        end
        OP_JAL: begin
          imm = {{12{inst[31]}}, inst[19:12], inst[20], inst[30:21], 1'b0};
          wr = 1'b1;
          res = core_pc + 32'd4;
          npc = core_pc + imm;
        end
        OP_JALR: begin
          wr = 1'b1;
          res = core_pc + 32'd4;
          npc = (a + immi) & 32'hFFFF_FFFE;
        end
        OP_BRANCH: begin
          imm = {{20{inst[31]}}, inst[7], inst[30:25], inst[11:8], 1'b0};
          case (fn3)
            3'd0: take = a == b;
            3'd1: take = a != b;
            3'd4: take = $signed(a) < $signed(b);
            3'd5: take = $signed(a) >= $signed(b);
            3'd6: take = a < b;
            3'd7: take = a >= b;
            default: take = 1'b0;
          endcase
          if (take) npc = core_pc + imm;
        end
        OP_LOAD: begin
          addr = a + immi;
          w = core_mem[word_of(addr)];
          lane = w >> (addr[1:0] * 8);
          wr = 1'b1;
          case (fn3)
            3'd0: res = {{24{lane[7]}}, lane[7:0]};
            3'd1: res = {{16{lane[15]}}, lane[15:0]};
            3'd2: res = w;
            3'd4: res = {24'd0, lane[7:0]};
            3'd5: res = {16'd0, lane[15:0]};
            default: wr = 1'b0;
          endcase
        end
        OP_STORE: begin
          addr = a + {{20{inst[31]}}, inst[31:25], inst[11:7]};
          mask = (fn3 == 3'd0) ? 32'hFF : (fn3 == 3'd1) ? 32'hFFFF : 32'hFFFF_FFFF;
          if (fn3 == 3'd2) begin
            core_mem[word_of(addr)] = b;
          end else if (fn3 <= 3'd1) begin
            w = core_mem[word_of(addr)];
            core_mem[word_of(addr)] = (w & ~(mask << (addr[1:0] * 8)))
                                      | ((b & mask) << (addr[1:0] * 8));
          end
          if (fn3 <= 3'd2) mem_valid[word_of(addr)] = 1'b1;
        end
        OP_IMM: begin
          wr = 1'b1;
          res = alu_result(fn3, a, immi, fn3 == 3'd5 && inst[30]);
        end
        OP_REG: begin
          wr = 1'b1;
          res = alu_result(fn3, a, b, inst[30]);
        end
        OP_FENCE: ;
        OP_SYSTEM: begin
          npc = core_pc;
          o.running = 1'b0;
        end
        default: npc = core_pc;
      endcase
      if (wr && d != 5'd0) begin
        core_regs[d] = res;
        o.reg_written = 1'b1;
        o.dest_reg = d;
        o.dest_value = res;
      end
      core_pc = npc;
    end
    o.next_pc = core_pc;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h", what, got, want);
    n_errors++;
  endtask

  task automatic check_rsp(string tag, rsp_t got, rsp_t want);
    if (got.running != want.running)
      report_mismatch({tag, " running"}, 32'(got.running), 32'(want.running));
    if (got.next_pc != want.next_pc)
      report_mismatch({tag, " next_pc"}, got.next_pc, want.next_pc);
    if (got.reg_written != want.reg_written)
      report_mismatch({tag, " reg_written"}, 32'(got.reg_written), 32'(want.reg_written));
    if (got.dest_reg != want.dest_reg)
      report_mismatch({tag, " dest_reg"}, 32'(got.dest_reg), 32'(want.dest_reg));
    if (got.dest_value != want.dest_value)
      report_mismatch({tag, " dest_value"}, got.dest_value, want.dest_value);
    if (got.reg_value != want.reg_value)
      report_mismatch({tag, " reg_value"}, got.reg_value, want.reg_value);
  endtask

  task automatic send_item(req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_rsps.push_back(core_predict(r));
  endtask

  task automatic send_checked(vec_t v);
    rsp_t p;
    send_item(v.req);
    p = expected_rsps[$];
    if (v.has_exp) check_rsp("directed row", p, v.exp);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_entry(logic [31:0] pc);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= pc;
    @(posedge clk);
    cfg_we <= 1'b0;
    core_pc = pc;
  endtask

  function automatic req_t mk_req(logic [1:0] t, logic [13:0] idx, logic [31:0] dat,
                                  logic [4:0] ri);
    req_t r;
    r.req_type = t;
    r.mem_index = idx;
    r.mem_data = dat;
    r.reg_index = ri;
    return r;
  endfunction

  function automatic logic [31:0] rand_inst();
    logic [31:0] i;
    logic [6:0] ops [11] = '{OP_LUI, OP_AUIPC, OP_JAL, OP_JALR, OP_BRANCH, OP_LOAD,
                             OP_STORE, OP_IMM, OP_REG, OP_FENCE, OP_SYSTEM};
    int k;
    i = $urandom();
    k = $urandom_range(99);
    if (k < 3) return i;
    k = $urandom_range(10);
    if ($urandom_range(3) == 0) k = 7;
    i[6:0] = ops[k];
    if (ops[k] == OP_LOAD || ops[k] == OP_STORE) i[19:15] = 5'd0;
    if (ops[k] == OP_LOAD && $urandom_range(1)) i[14:12] = 3'($urandom_range(5));
    return i;
  endfunction

  // A random program: a block of words at a random base, loads and stores mostly through
  // x0 so that addresses stay within the immediate's reach, unwritten load and sub-word
  // store words filled first, and the run stops whenever the PC leaves written memory.
  task automatic run_program(int n_steps);
    logic [13:0] base;
    logic [31:0] inst;
    int n;
    base = 14'($urandom_range(MemWords - 64));
    n = $urandom_range(4, 24);
    for (int k = 0; k < n; k++) begin
      inst = rand_inst();
      send_item(mk_req(REQ_MEM_WRITE, base + 14'(k), inst, 5'd0));
    end
    write_entry({16'($urandom_range(65535)), base, 2'($urandom_range(3))});
    for (int s = 0; s < n_steps; s++) begin
      if (!mem_valid[word_of(core_pc)]) break;
      inst = core_mem[word_of(core_pc)];
      if ((inst[6:0] == OP_LOAD) && !mem_valid[word_of(core_regs[inst[19:15]]
          + {{20{inst[31]}}, inst[31:20]})]) begin
        send_item(mk_req(REQ_MEM_WRITE, word_of(core_regs[inst[19:15]]
          + {{20{inst[31]}}, inst[31:20]}), $urandom(), 5'd0));
      end
      if (((inst[6:0] == OP_STORE) && inst[14:12] <= 3'd1) && !mem_valid[word_of(
          core_regs[inst[19:15]] + {{20{inst[31]}}, inst[31:25], inst[11:7]})]) begin
        send_item(mk_req(REQ_MEM_WRITE, word_of(core_regs[inst[19:15]]
          + {{20{inst[31]}}, inst[31:25], inst[11:7]}), $urandom(), 5'd0));
      end
      send_item(mk_req(REQ_STEP, 14'($urandom()), $urandom(), 5'($urandom())));
      if ($urandom_range(4) == 0)
        send_item(mk_req(REQ_REG_READ, 14'($urandom()), $urandom(), 5'($urandom())));
    end
  endtask

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_rsps.size() == 0) begin
        report_mismatch("unexpected transaction", out_ch.data.next_pc, 32'd0);
      end else begin
        rsp_t e;
        e = expected_rsps.pop_front();
        check_rsp("response", out_ch.data, e);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    vec_t rows [$];
    vec_t v;
    logic [1:0] rtype;
    int kind;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    foreach (core_regs[i]) core_regs[i] = '0;
    foreach (mem_valid[i]) mem_valid[i] = 1'b0;
    core_pc = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset state, extremes of fields, every opcode but JALR and the corner cases.
    v.has_exp = 1'b1;
    v.exp = '0; v.exp.running = 1'b1;
    v.req = mk_req(REQ_REG_READ, 14'h3FFF, 32'hFFFF_FFFF, 5'd31); rows.push_back(v);
    v.req = mk_req(REQ_MEM_WRITE, 14'h3FFF, 32'hFFFF_FFFF, 5'd31); rows.push_back(v);
    v.req = mk_req(REQ_IGNORED, 14'h3FFF, 32'hFFFF_FFFF, 5'd31); rows.push_back(v);
    v.has_exp = 1'b0;
    rows.push_back('{mk_req(REQ_MEM_WRITE, 14'd0, 32'h8000_00B7, 5'd0), 0, '0}); // lui x1
    rows.push_back('{mk_req(REQ_MEM_WRITE, 14'd1, 32'hFFF0_C113, 5'd0), 0, '0}); // xori
    rows.push_back('{mk_req(REQ_MEM_WRITE, 14'd2, 32'h41F0_D193, 5'd0), 0, '0}); // srai
    rows.push_back('{mk_req(REQ_MEM_WRITE, 14'd3, 32'h4020_8233, 5'd0), 0, '0}); // sub
    rows.push_back('{mk_req(REQ_MEM_WRITE, 14'd4, 32'h0020_0FA3, 5'd0), 0, '0}); // sb x2,31
    rows.push_back('{mk_req(REQ_MEM_WRITE, 14'd5, 32'h01F0_1283, 5'd0), 0, '0}); // lh 31
    rows.push_back('{mk_req(REQ_MEM_WRITE, 14'd6, 32'h0010_0037, 5'd0), 0, '0}); // lui x0
    rows.push_back('{mk_req(REQ_MEM_WRITE, 14'd7, 32'h0000_000F, 5'd0), 0, '0}); // fence
    rows.push_back('{mk_req(REQ_MEM_WRITE, 14'd8, 32'h0020_8463, 5'd0), 0, '0}); // beq
    rows.push_back('{mk_req(REQ_MEM_WRITE, 14'd9, 32'h0000_0017, 5'd0), 0, '0});
    rows.push_back('{mk_req(REQ_MEM_WRITE, 14'd10, 32'h0080_036F, 5'd0), 0, '0}); // jal x6
    rows.push_back('{mk_req(REQ_MEM_WRITE, 14'd12, 32'h0000_007F, 5'd0), 0, '0}); // unknown
    rows.push_back('{mk_req(REQ_MEM_WRITE, 14'd13, 32'h0000_0073, 5'd0), 0, '0}); // system
    foreach (rows[i]) send_checked(rows[i]);
    rows.delete();
    write_entry(32'd0);
    v = '{mk_req(REQ_STEP, 14'h3FFF, 32'hFFFF_FFFF, 5'd31), 0, '0};
    repeat (12) send_checked(v);
    write_entry(32'd52);
    send_checked(v);
    write_entry(32'd48);
    send_checked(v);
    for (int r = 0; r < 32; r += 31)
      send_checked('{mk_req(REQ_REG_READ, 14'd0, 32'd0, 5'(r)), 0, '0});
    write_entry(32'hFFFF_FFFF);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 47 : 0;
      recv_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 19 : 0;
      for (int p = 0; p < 22; p++) begin
        run_program($urandom_range(10, 30));
        if ($urandom_range(3) == 0) begin
          kind = $urandom_range(2);
          rtype = (kind == 0) ? REQ_MEM_WRITE : (kind == 1) ? REQ_REG_READ : REQ_IGNORED;
          send_item(mk_req(rtype, 14'($urandom()), $urandom(), 5'($urandom())));
        end
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
